### design/rational_arithmetic_unit_assert.svh
// Assertion macros for the rational arithmetic unit checker.
// Each macro expands to one labeled concurrent assertion clocked on aclk.
`ifndef RATIONAL_ARITHMETIC_UNIT_ASSERT_SVH
`define RATIONAL_ARITHMETIC_UNIT_ASSERT_SVH

// Clocked assertion, disabled while reset is asserted
`define RAU_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Implication form, antecedent and consequent in the same cycle
`define RAU_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

`endif

### design/rau_pkg.sv
// Shared types, constants and helpers for the rational arithmetic unit.
// No dependencies; used by the top level and its checker.
package rau_pkg;

    localparam int OPERAND_WIDTH = 32;  // significant operand bits, 8..32
    localparam int FIELD_W       = 32;
    localparam int NUM_W         = 64;
    localparam int DEN_W         = 62;
    localparam int CMD_W         = 2;
    localparam int S_DATA_W      = 128;
    localparam int M_DATA_W      = 128;
    localparam int STATUS_W      = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD = 2'd0,
        CMD_SUB = 2'd1,
        CMD_MUL = 2'd2,
        CMD_DIV = 2'd3
    } cmd_t;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_ZERO_DEN = 2'd1;
    localparam logic [STATUS_W-1:0] ST_DIV_ZERO = 2'd2;

    // Low OPERAND_WIDTH bits as two's complement, most negative value saturated
    function automatic logic signed [FIELD_W-1:0] sat_operand(input logic [FIELD_W-1:0] raw);
        logic [OPERAND_WIDTH-1:0] u;
        logic signed [FIELD_W-1:0] v;
        u = raw[OPERAND_WIDTH-1:0];
        v = FIELD_W'($signed(u));
        if (u == {1'b1, {(OPERAND_WIDTH-1){1'b0}}}) begin
            v = FIELD_W'($signed({1'b1, {(OPERAND_WIDTH-2){1'b0}}, 1'b1}));
        end
        return v;
    endfunction

endpackage

### design/rational_arithmetic_unit.sv
// Rational arithmetic unit: add, subtract, multiply or divide two signed fractions
// and return the fully reduced result. Depends on rau_pkg.
//
// One word is taken at a time; s_tready is high only while the unit is idle.
// A word runs through the cross products (one shared 32x32 multiplier,
// three products), then binary gcd (one 64-bit compare and subtract per cycle),
// then the two restoring divisions by the gcd, and then the output register.
// Error words go straight from the check to the output register; zero results skip
// the gcd and the divisions. The output register lets the next word in while a
// finished result waits for m_tready.
module rational_arithmetic_unit (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // [31:0] a_numerator, [63:32] a_denominator,
    // [95:64] b_numerator, [127:96] b_denominator
    input  logic [rau_pkg::S_DATA_W-1:0]   s_tdata,
    // [1:0] command
    input  logic [rau_pkg::CMD_W-1:0]      s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [63:0] result_numerator, [125:64] result_denominator, rest zero
    output logic [rau_pkg::M_DATA_W-1:0]   m_tdata,
    // [1:0] status
    output logic [rau_pkg::STATUS_W-1:0]   m_tuser
);
    import rau_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_CHECK, S_MUL_NUM, S_MUL_DEN, S_MUL_CROSS,
        S_SUM, S_PREP, S_GCD, S_DIV, S_FINISH
    } state_t;

    state_t                     state_reg;
    cmd_t                       cmd_reg;
    logic signed [FIELD_W-1:0]  an_reg, ad_reg, bn_reg, bd_reg;
    logic signed [NUM_W-1:0]    prod_reg, num_reg, den_reg;
    logic                       neg_reg;
    logic [NUM_W-1:0]           x_reg, y_reg, g_reg, mag_n_reg, mag_d_reg;
    logic [5:0]                 k_reg, cnt_reg;
    logic [NUM_W-1:0]           div_q_reg, div_r_reg, qn_reg;
    logic                       div_den_reg;
    logic [NUM_W-1:0]           res_num_reg;
    logic [DEN_W-1:0]           res_den_reg;
    logic [STATUS_W-1:0]        res_status_reg;
    logic                       m_valid_reg;
    logic [NUM_W-1:0]           m_num_reg;
    logic [DEN_W-1:0]           m_den_reg;
    logic [STATUS_W-1:0]        m_status_reg;

    // Shared multiplier operand select
    logic signed [FIELD_W-1:0]  mul_a, mul_b;
    logic signed [NUM_W-1:0]    mul_out;

    always_comb begin
        unique case (state_reg)
            S_MUL_NUM: begin
                mul_a = an_reg;
                mul_b = (cmd_reg == CMD_MUL) ? bn_reg : bd_reg;
            end
            S_MUL_DEN: begin
                mul_a = ad_reg;
                mul_b = (cmd_reg == CMD_DIV) ? bn_reg : bd_reg;
            end
            default: begin
                mul_a = bn_reg;
                mul_b = ad_reg;
            end
        endcase
    end

    assign mul_out = NUM_W'(mul_a) * NUM_W'(mul_b);

    // Numerator combine after the cross product
    logic signed [NUM_W-1:0] sum_next;
    always_comb begin
        unique case (cmd_reg)
            CMD_ADD: sum_next = num_reg + prod_reg;
            CMD_SUB: sum_next = num_reg - prod_reg;
            default: sum_next = num_reg;
        endcase
    end

    // Magnitudes of the raw fraction
    logic [NUM_W-1:0] abs_num, abs_den;
    assign abs_num = num_reg[NUM_W-1] ? NUM_W'(-num_reg) : NUM_W'(num_reg);
    assign abs_den = den_reg[NUM_W-1] ? NUM_W'(-den_reg) : NUM_W'(den_reg);

    // Gcd step: one compare and subtract
    logic [NUM_W:0]   gcd_diff;
    logic [NUM_W-1:0] gcd_x_next, gcd_y_next;
    assign gcd_diff   = {1'b0, x_reg} - {1'b0, y_reg};
    assign gcd_x_next = gcd_diff[NUM_W] ? x_reg : y_reg;
    assign gcd_y_next = gcd_diff[NUM_W] ? NUM_W'(y_reg - x_reg) : gcd_diff[NUM_W-1:0];

    // Restoring division step
    logic [NUM_W:0]   div_r2;
    logic [NUM_W+1:0] div_diff;
    logic             div_ge;
    logic [NUM_W-1:0] div_r_next, div_q_next;
    assign div_r2     = {div_r_reg, div_q_reg[NUM_W-1]};
    assign div_diff   = {1'b0, div_r2} - {2'b00, g_reg};
    assign div_ge     = ~div_diff[NUM_W+1];
    assign div_r_next = div_ge ? div_diff[NUM_W-1:0] : div_r2[NUM_W-1:0];
    assign div_q_next = {div_q_reg[NUM_W-2:0], div_ge};

    logic s_fire, out_free;
    assign s_fire   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;

    // Sequencer, datapath and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            // drain the output word unless a new one is loaded this cycle
            if (m_valid_reg && m_tready && !(state_reg == S_FINISH && out_free)) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (s_fire) begin
                        cmd_reg   <= cmd_t'(s_tuser);
                        an_reg    <= sat_operand(s_tdata[31:0]);
                        ad_reg    <= sat_operand(s_tdata[63:32]);
                        bn_reg    <= sat_operand(s_tdata[95:64]);
                        bd_reg    <= sat_operand(s_tdata[127:96]);
                        state_reg <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    res_num_reg <= '0;
                    res_den_reg <= DEN_W'(1);
                    if (ad_reg == '0 || bd_reg == '0) begin
                        res_status_reg <= ST_ZERO_DEN;
                        state_reg      <= S_FINISH;
                    end else if (cmd_reg == CMD_DIV && bn_reg == '0) begin
                        res_status_reg <= ST_DIV_ZERO;
                        state_reg      <= S_FINISH;
                    end else begin
                        res_status_reg <= ST_OK;
                        state_reg      <= S_MUL_NUM;
                    end
                end
                S_MUL_NUM: begin
                    prod_reg  <= mul_out;
                    state_reg <= S_MUL_DEN;
                end
                S_MUL_DEN: begin
                    num_reg   <= prod_reg;
                    prod_reg  <= mul_out;
                    state_reg <= S_MUL_CROSS;
                end
                S_MUL_CROSS: begin
                    den_reg   <= prod_reg;
                    prod_reg  <= mul_out;
                    state_reg <= S_SUM;
                end
                S_SUM: begin
                    num_reg   <= sum_next;
                    state_reg <= S_PREP;
                end
                S_PREP: begin
                    if (num_reg == '0) begin
                        state_reg <= S_FINISH;
                    end else begin
                        neg_reg   <= num_reg[NUM_W-1] ^ den_reg[NUM_W-1];
                        mag_n_reg <= abs_num;
                        mag_d_reg <= abs_den;
                        x_reg     <= abs_num;
                        y_reg     <= abs_den;
                        k_reg     <= '0;
                        state_reg <= S_GCD;
                    end
                end
                S_GCD: begin
                    priority if (y_reg == '0) begin
                        g_reg       <= x_reg << k_reg;
                        div_q_reg   <= mag_n_reg;
                        div_r_reg   <= '0;
                        cnt_reg     <= 6'd63;
                        div_den_reg <= 1'b0;
                        state_reg   <= S_DIV;
                    end else if (!x_reg[0] && !y_reg[0]) begin
                        x_reg <= x_reg >> 1;
                        y_reg <= y_reg >> 1;
                        k_reg <= k_reg + 6'd1;
                    end else if (!y_reg[0]) begin
                        y_reg <= y_reg >> 1;
                    end else if (!x_reg[0]) begin
                        x_reg <= x_reg >> 1;
                    end else begin
                        x_reg <= gcd_x_next;
                        y_reg <= gcd_y_next;
                    end
                end
                S_DIV: begin
                    if (cnt_reg != '0) begin
                        div_q_reg <= div_q_next;
                        div_r_reg <= div_r_next;
                        cnt_reg   <= cnt_reg - 6'd1;
                    end else if (!div_den_reg) begin
                        qn_reg      <= div_q_next;
                        div_q_reg   <= mag_d_reg;
                        div_r_reg   <= '0;
                        cnt_reg     <= 6'd63;
                        div_den_reg <= 1'b1;
                    end else begin
                        res_num_reg <= neg_reg ? NUM_W'(-qn_reg) : qn_reg;
                        res_den_reg <= div_q_next[DEN_W-1:0];
                        state_reg   <= S_FINISH;
                    end
                end
                S_FINISH: begin
                    if (out_free) begin
                        m_valid_reg  <= 1'b1;
                        m_num_reg    <= res_num_reg;
                        m_den_reg    <= res_den_reg;
                        m_status_reg <= res_status_reg;
                        state_reg    <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(M_DATA_W-NUM_W-DEN_W){1'b0}}, m_den_reg, m_num_reg};
    assign m_tuser  = m_status_reg;

endmodule

### design/rau_checker.sv
// Port-level checker for the rational arithmetic unit, bound to the top level.
// Depends on rau_pkg and rational_arithmetic_unit_assert.svh.
`include "rational_arithmetic_unit_assert.svh"

module rau_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [rau_pkg::M_DATA_W-1:0]  m_tdata,
    input logic [rau_pkg::STATUS_W-1:0]  m_tuser
);
    import rau_pkg::*;

    logic s_fire;
    assign s_fire = s_tvalid && s_tready;

    // a stalled result word holds
    `RAU_ASSERT(a_out_hold,
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)),
        "result word changed while stalled")
    // the unit is busy right after taking a word
    `RAU_ASSERT(a_busy_after_accept, s_fire |=> !s_tready, "ready right after accept")
    // error words carry 0/1
    `RAU_ASSERT_IMPL(a_err_payload, m_tvalid && m_tuser != ST_OK,
        m_tdata[NUM_W-1:0] == '0 && m_tdata[NUM_W+DEN_W-1:NUM_W] == DEN_W'(1),
        "error word payload not 0/1")
    // ok words have a nonzero denominator
    `RAU_ASSERT_IMPL(a_den_nonzero, m_tvalid && m_tuser == ST_OK,
        m_tdata[NUM_W+DEN_W-1:NUM_W] != '0, "zero denominator in result")

endmodule

bind rational_arithmetic_unit rau_checker u_rau_checker (.*);

### tb/tb_rational_arithmetic_unit.sv
// Testbench for the rational arithmetic unit: random and directed fraction words,
// an in-bench predictor of the reduced result, and a scoreboard on the result stream.
// Depends on rau_pkg and the rational_arithmetic_unit top level.
module tb_rational_arithmetic_unit;
    import rau_pkg::*;

    // queued item: command in the low bits, then the four operands
    localparam int ITEM_W = CMD_W + 4 * FIELD_W;

    typedef struct packed {
        logic [NUM_W-1:0]    num;
        logic [DEN_W-1:0]    den;
        logic [STATUS_W-1:0] status;
    } fraction_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata = '0;
    logic [CMD_W-1:0]      s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_DATA_W-1:0]   m_tdata;
    logic [STATUS_W-1:0]   m_tuser;

    logic [ITEM_W-1:0]   pending_words[$];
    fraction_t           expected_fractions[$];
    int                  error_count = 0;
    int                  results_seen = 0;
    int                  words_sent = 0;
    int                  error_results = 0;
    bit                  calm = 1'b0;     // no idling on either side
    bit                  hold_sender = 1'b0;

    rational_arithmetic_unit uut (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Operand as seen by the unit: low OPERAND_WIDTH bits, most negative saturated
    function automatic longint signed to_operand(input logic [FIELD_W-1:0] raw);
        logic [OPERAND_WIDTH-1:0] u;
        longint signed v;
        u = raw[OPERAND_WIDTH-1:0];
        v = longint'($signed(u));
        if (v == -(64'sd1 <<< (OPERAND_WIDTH - 1))) v = v + 1;
        return v;
    endfunction

    function automatic logic [63:0] binary_gcd(input logic [63:0] x, input logic [63:0] y);
        int shift;
        logic [63:0] t;
        shift = 0;
        if (x == 0) return y;
        if (y == 0) return x;
        while (((x | y) & 1) == 0) begin
            x >>= 1;
            y >>= 1;
            shift++;
        end
        while ((x & 1) == 0) x >>= 1;
        while (y != 0) begin
            while ((y & 1) == 0) y >>= 1;
            if (x > y) begin
                t = x;
                x = y;
                y = t;
            end
            y -= x;
        end
        return x << shift;
    endfunction

    // Reduced fraction for one input word
    function automatic fraction_t reduce_fraction(input logic [ITEM_W-1:0] w);
        cmd_t cmd;
        longint signed an, ad, bn, bd, num, den;
        logic [63:0] mn, md, g;
        fraction_t r;
        cmd = cmd_t'(w[1:0]);
        an = to_operand(w[33:2]);
        ad = to_operand(w[65:34]);
        bn = to_operand(w[97:66]);
        bd = to_operand(w[129:98]);
        r.num = '0;
        r.den = DEN_W'(1);
        r.status = ST_OK;
        if (ad == 0 || bd == 0) begin
            r.status = ST_ZERO_DEN;
            return r;
        end
        if (cmd == CMD_DIV && bn == 0) begin
            r.status = ST_DIV_ZERO;
            return r;
        end
        case (cmd)
            CMD_ADD: begin num = an * bd + bn * ad; den = ad * bd; end
            CMD_SUB: begin num = an * bd - bn * ad; den = ad * bd; end
            CMD_MUL: begin num = an * bn; den = ad * bd; end
            default: begin num = an * bd; den = ad * bn; end
        endcase
        if (num == 0) return r;
        mn = num < 0 ? -num : num;
        md = den < 0 ? -den : den;
        g = binary_gcd(mn, md);
        mn = mn / g;
        md = md / g;
        r.num = ((num < 0) != (den < 0)) ? -mn : mn;
        r.den = md[DEN_W-1:0];
        return r;
    endfunction

    function automatic logic [ITEM_W-1:0] pack_word(input cmd_t cmd,
            input logic [31:0] an, input logic [31:0] ad,
            input logic [31:0] bn, input logic [31:0] bd);
        return {bd, bn, ad, an, cmd};
    endfunction

    // Random operand: small, full width or edge values
    function automatic logic [31:0] rand_operand();
        case ($urandom_range(9))
            0: return 32'h0;
            1: return 32'h8000_0000;
            2: return 32'h7fff_ffff;
            3: return 32'h8000_0001;
            4, 5: return $urandom;
            default: return 32'($signed($urandom_range(200)) - 100);
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
            input logic [63:0] want);
        $display("mismatch in result %0d: %s got %0h expected %0h",
                 results_seen, what, got, want);
        error_count++;
    endtask

    // Driver: presents queued words, idles at random
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                words_sent <= words_sent + 1;
            end
            if (!(s_tvalid && !s_tready)) begin
                if (pending_words.size() > 0 && !hold_sender
                        && (calm || $urandom_range(99) >= 36)) begin
                    s_tdata  <= pending_words[0][ITEM_W-1:CMD_W];
                    s_tuser  <= pending_words[0][CMD_W-1:0];
                    s_tvalid <= 1'b1;
                    expected_fractions.push_back(reduce_fraction(pending_words[0]));
                    void'(pending_words.pop_front());
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compares each result word with the oldest prediction
    always @(posedge aclk) begin
        fraction_t want;
        if (aresetn) begin
            m_tready <= calm || $urandom_range(99) >= 36;
            if (m_tvalid && m_tready) begin
                results_seen <= results_seen + 1;
                if (expected_fractions.size() == 0) begin
                    report_mismatch("unexpected word", m_tdata[63:0], 0);
                end else begin
                    want = expected_fractions.pop_front();
                    if (m_tuser != want.status) report_mismatch("status", m_tuser, want.status);
                    if (m_tdata[63:0] != want.num)
                        report_mismatch("numerator", m_tdata[63:0], want.num);
                    if (m_tdata[125:64] != want.den)
                        report_mismatch("denominator", m_tdata[125:64], want.den);
                    if (m_tdata[127:126] != 0)
                        report_mismatch("pad bits", m_tdata[127:126], 0);
                    if (want.status != ST_OK) error_results++;
                end
            end
        end
    end

    // Stimulus
    initial begin
        cmd_t cmd;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        // directed: each op with edge operands and the error cases
        for (int c = 0; c < 4; c++) begin
            cmd = cmd_t'(c);
            pending_words.push_back(pack_word(cmd, 32'h7fff_ffff, 32'h8000_0000,
                                              32'h8000_0000, 32'h7fff_ffff));
            pending_words.push_back(pack_word(cmd, 32'h8000_0001, 32'h7fff_fffe,
                                              32'h3, 32'hffff_fffa));
            pending_words.push_back(pack_word(cmd, 32'h0, 32'h5, 32'h0, 32'h7));
            pending_words.push_back(pack_word(cmd, 32'h1, 32'h0, 32'h0, 32'h3));
        end
        pending_words.push_back(pack_word(CMD_DIV, 32'h6, 32'h4, 32'h0, 32'h0));
        pending_words.push_back(pack_word(CMD_ADD, 32'h1, 32'h2, 32'hffff_ffff, 32'h2));
        pending_words.push_back(pack_word(CMD_SUB, 32'h1, 32'h3, 32'h1, 32'h3));
        // random, with a calm stretch and a full drain in the middle
        for (int i = 0; i < 2000; i++) begin
            cmd = cmd_t'($urandom_range(3));
            pending_words.push_back(pack_word(cmd, rand_operand(), rand_operand(),
                                              rand_operand(), rand_operand()));
            if (i == 600) begin
                wait (pending_words.size() == 0);
                hold_sender = 1'b1;
                wait (expected_fractions.size() == 0 && !m_tvalid);
                hold_sender = 1'b0;
                calm = 1'b1;
            end
            if (i == 900) begin
                // keep the calm stretch until its words have gone out
                wait (pending_words.size() == 0);
                calm = 1'b0;
            end
        end
        wait (pending_words.size() == 0 && expected_fractions.size() == 0);
        repeat (400) @(posedge aclk);
        $display("covered %0d words, %0d results, %0d flagged as errors",
                 words_sent, results_seen, error_results);
        if (error_count == 0) begin
            $display("tb_rational_arithmetic_unit: done, clean");
        end else begin
            $display("tb_rational_arithmetic_unit: done, errors");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #50_000_000;
        $display("tb_rational_arithmetic_unit: done, errors");
        $finish;
    end
endmodule
